// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle property failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle property failed.");

`endif

// File: design/i2a_pkg.sv
package i2a_pkg;

  // Number of value bits that take part in the conversion.
  localparam int VALUE_WIDTH = 64;

  // Digit buffer sizing: radix 2 gives the most digits.
  localparam int MAX_DIGITS = VALUE_WIDTH;
  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int DIGIT_W = 4;

  // Division by ten handles a byte of dividend per cycle.
  localparam int DIV_BITS = 8;
  localparam int DIV_W = ((VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DSTEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // ASCII codes.
  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_QUESTION = 7'h3F;

  // Supported radix values.
  localparam logic [5:0] RADIX_BIN = 6'd2;
  localparam logic [5:0] RADIX_OCT = 6'd8;
  localparam logic [5:0] RADIX_DEC = 6'd10;
  localparam logic [5:0] RADIX_HEX = 6'd16;
  localparam logic [5:0] RADIX_DEF0 = 6'd0;
  localparam logic [5:0] RADIX_DEF1 = 6'd1;

  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  radix;
    logic        uppercase;
  } in_req_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
  } out_res_t;

  typedef enum logic [2:0] {
    MODE_BIN,
    MODE_OCT,
    MODE_HEX,
    MODE_DEC,
    MODE_BAD
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pow2_step;
    logic zero_write;
    logic div_start;
    logic div_step;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  val_zero;
    logic  cnt_zero;
    logic  cnt_one;
    logic  div_last;
  } status_t;

  // Maps a digit value to its ASCII character.
  function automatic logic [6:0] digit_to_char(input logic [DIGIT_W-1:0] digit,
                                               input logic upper);
    logic [6:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (digit < 4'd10) begin
      return CHAR_ZERO + 7'(digit);
    end
    return base + 7'(digit - 4'd10);
  endfunction

endpackage

// File: design/i2a_ram.sv
module i2a_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: design/i2a_ctrl.sv
module i2a_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  i2a_pkg::status_t status,
  output i2a_pkg::cmd_t    cmd,
  output logic             busy
);

  import i2a_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // Command decode and next state.
  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (status.mode == MODE_BAD || (status.val_zero && status.cnt_zero)) begin
          // A lone character: either the zero digit or the bad-radix mark.
          cmd.zero_write = 1'b1;
          state_nxt = ST_EMIT;
        end else if (status.val_zero) begin
          state_nxt = ST_EMIT;
        end else if (status.mode == MODE_DEC) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          cmd.pow2_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_CONV;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.cnt_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: design/i2a_datapath.sv
module i2a_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  i2a_pkg::in_req_t  in_req,
  input  i2a_pkg::cmd_t     cmd,
  output i2a_pkg::status_t  status,
  output i2a_pkg::out_res_t out_res,
  output logic              out_valid
);

  import i2a_pkg::*;

  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] val_shift_nxt;
  mode_t                  mode_r, mode_nxt;
  logic                   upper_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_m1;
  logic [DIV_W-1:0]       div_r;
  logic [DIV_W-1:0]       quo_r, quo_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [DSTEP_W-1:0]     div_cnt_r;
  logic                   div_last;
  logic [DIGIT_W-1:0]     pow2_digit;
  logic                   out_valid_r;
  logic                   out_last_r;
  logic                   ram_we;
  logic [DIGIT_W-1:0]     ram_wdata;
  logic [DIGIT_W-1:0]     ram_rdata;

  // Radix decode for a new request.
  always_comb begin
    case (in_req.radix) inside
      RADIX_DEF0, RADIX_DEF1, RADIX_DEC: mode_nxt = MODE_DEC;
      RADIX_BIN:                         mode_nxt = MODE_BIN;
      RADIX_OCT:                         mode_nxt = MODE_OCT;
      RADIX_HEX:                         mode_nxt = MODE_HEX;
      default:                           mode_nxt = MODE_BAD;
    endcase
  end

  // Low digit and shifted value for the power-of-two radices.
  always_comb begin
    case (mode_r)
      MODE_BIN: begin
        pow2_digit = {3'b000, val_r[0]};
        val_shift_nxt = val_r >> 1;
      end
      MODE_OCT: begin
        pow2_digit = {1'b0, val_r[2:0]};
        val_shift_nxt = val_r >> 3;
      end
      MODE_HEX: begin
        pow2_digit = val_r[3:0];
        val_shift_nxt = val_r >> 4;
      end
      default: begin
        pow2_digit = '0;
        val_shift_nxt = val_r;
      end
    endcase
  end

  // One byte of restoring long division by ten.
  always_comb begin
    logic [DIGIT_W-1:0]  rem;
    logic [DIGIT_W:0]    trial;
    logic [DIV_BITS-1:0] dbits;
    logic [DIV_BITS-1:0] qbits;
    rem = rem_r;
    dbits = div_r[DIV_W-1 -: DIV_BITS];
    qbits = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      trial = {rem, dbits[i]};
      if (trial >= 5'd10) begin
        rem = 4'(trial - 5'd10);
        qbits[i] = 1'b1;
      end else begin
        rem = trial[DIGIT_W-1:0];
      end
    end
    rem_nxt = rem;
    quo_nxt = (quo_r << DIV_BITS) | DIV_W'(qbits);
  end

  assign div_last = (div_cnt_r == DSTEP_W'(DIV_STEPS - 1));
  assign cnt_m1 = cnt_r - CNT_W'(1);

  // Control registers: digit count, division step and output strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      div_cnt_r <= '0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.pow2_step || (cmd.div_step && div_last)) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.zero_write) begin
        cnt_r <= CNT_W'(1);
      end else if (cmd.emit) begin
        cnt_r <= cnt_m1;
      end
      if (cmd.div_start) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DSTEP_W'(1);
      end
      out_valid_r <= cmd.emit;
      out_last_r <= cmd.emit && (cnt_r == CNT_W'(1));
    end
  end

  // Working value, division registers and request options.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_req.value[VALUE_WIDTH-1:0];
      mode_r <= mode_nxt;
      upper_r <= in_req.uppercase;
    end else if (cmd.pow2_step) begin
      val_r <= val_shift_nxt;
    end else if (cmd.div_step && div_last) begin
      val_r <= quo_nxt[VALUE_WIDTH-1:0];
    end
    if (cmd.div_start) begin
      div_r <= DIV_W'(val_r);
      quo_r <= '0;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      div_r <= div_r << DIV_BITS;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Digits are stored least significant first and read back in reverse.
  assign ram_we = cmd.zero_write || cmd.pow2_step || (cmd.div_step && div_last);

  always_comb begin
    if (cmd.zero_write) begin
      ram_wdata = '0;
    end else if (cmd.pow2_step) begin
      ram_wdata = pow2_digit;
    end else begin
      ram_wdata = rem_nxt;
    end
  end

  i2a_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(ram_wdata),
    .raddr(cnt_m1[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // Status toward the controller.
  assign status.mode = mode_r;
  assign status.val_zero = (val_r == '0);
  assign status.cnt_zero = (cnt_r == '0);
  assign status.cnt_one = (cnt_r == CNT_W'(1));
  assign status.div_last = div_last;

  // Character output.
  assign out_res.digit_char = (mode_r == MODE_BAD) ? CHAR_QUESTION
                                                   : digit_to_char(ram_rdata, upper_r);
  assign out_res.last = out_last_r;
  assign out_valid = out_valid_r;

endmodule

// File: design/integer_to_ascii_radix.sv
// Converts one unsigned value to ASCII digits in radix 2, 8, 10 or 16 (0 and 1 mean 10;
// any other radix yields a single '?'). A request is taken when start is high and busy is
// low. Characters come out most significant first, one per cycle on out_valid, with
// out_res.last on the final one; the receiver cannot stall them, so it must take every
// character in the cycle it is shown. A request runs in two phases. Conversion writes the
// digits least significant first into a small digit buffer: radix 2, 8 and 16 take one
// digit per cycle, while radix 10 finds each digit by a long division by ten, a start
// step and then the division steps, which retire eight dividend bits per cycle. Playback
// then reads the buffer in reverse at one character per cycle. The longest request is a
// 20-digit decimal value. Busy falls in the cycle that shows the last character, and a
// new request may be given then.
module integer_to_ascii_radix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  i2a_pkg::in_req_t  in_req,
  output i2a_pkg::out_res_t out_res,
  output logic              out_valid
);

  import i2a_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  i2a_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Value registers, divider, digit buffer and character output.
  i2a_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cmd      (cmd),
    .status   (status),
    .out_res  (out_res),
    .out_valid(out_valid)
  );

endmodule

// File: design/i2a_checker.sv
`include "assert_macros.svh"

module i2a_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input i2a_pkg::out_res_t out_res,
  input logic              out_valid
);

  import i2a_pkg::*;

  // Characters only appear as part of a request that was in progress.
  `ASSERT_SAME(a_out_in_request, out_valid, $past(busy))

  // A taken request makes the block busy.
  `ASSERT_NEXT(a_start_busy, start && !busy, busy)

  // Characters of one value come in an unbroken run.
  `ASSERT_NEXT(a_run_unbroken, out_valid && !out_res.last, out_valid)

  // The last character ends the run and frees the block.
  `ASSERT_NEXT(a_last_ends_run, out_valid && out_res.last, !out_valid)
  `ASSERT_SAME(a_last_not_busy, out_valid && out_res.last, !busy)

endmodule

bind integer_to_ascii_radix i2a_checker u_checker (.*);

// File: tb/tb_integer_to_ascii_radix.sv
`timescale 1ns / 100ps

module tb_integer_to_ascii_radix;
  import i2a_pkg::*;

  localparam int RANDOM_REQUESTS = 145;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PERCENT = 9;

  // Radix values that the block does not support.
  localparam logic [5:0] RADIX_BAD_LOW = 6'd3;
  localparam logic [5:0] RADIX_BAD_NINE = 6'd9;
  localparam logic [5:0] RADIX_BAD_ABOVE_HEX = 6'd17;
  localparam logic [5:0] RADIX_BAD_TOP = 6'd63;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? ALL_ONES : ((64'd1 << VALUE_WIDTH) - 64'd1);

  // One directed row: the request and, where it is obvious, the text it must produce.
  typedef struct {
    in_req_t req;
    string   text;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_req_t   in_req;
  out_res_t  out_res;
  logic      out_valid;

  out_res_t  pending_chars[$];
  row_t      directed_rows[$];
  int        error_count;
  int        cycle_count;

  integer_to_ascii_radix dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_res  (out_res),
    .out_valid(out_valid)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the characters of one request and queues them, most significant first.
  function automatic void predict_digits(input in_req_t req);
    logic [63:0] v;
    logic [63:0] mask;
    logic [5:0]  base;
    int          shift;
    string       digits;
    logic [6:0]  rev[$];
    out_res_t    res;
    v = req.value & VALUE_MASK;
    base = req.radix;
    digits = req.uppercase ? "0123456789ABCDEF" : "0123456789abcdef";
    if (base == RADIX_DEF0 || base == RADIX_DEF1) begin
      base = RADIX_DEC;
    end
    if (base == RADIX_BIN || base == RADIX_OCT || base == RADIX_HEX) begin
      shift = (base == RADIX_HEX) ? 4 : (base == RADIX_OCT) ? 3 : 1;
      mask = 64'(base) - 64'd1;
      do begin
        rev.push_back(7'(digits[int'(v & mask)]));
        v = v >> shift;
      end while (v != 64'd0);
    end else if (base == RADIX_DEC) begin
      do begin
        rev.push_back(7'(digits[int'(v % 64'd10)]));
        v = v / 64'd10;
      end while (v != 64'd0);
    end else begin
      rev.push_back(CHAR_QUESTION);
    end
    for (int k = rev.size() - 1; k >= 0; k--) begin
      res.digit_char = rev[k];
      res.last = (k == 0);
      pending_chars.push_back(res);
    end
  endfunction

  // Queues characters typed in directly, the final one marked as last.
  function automatic void push_text(input string text);
    out_res_t res;
    for (int k = 0; k < text.len(); k++) begin
      res.digit_char = 7'(text[k]);
      res.last = (k == text.len() - 1);
      pending_chars.push_back(res);
    end
  endfunction

  function automatic void add_row(input logic [63:0] value, input logic [5:0] radix,
                                  input logic upper, input string text);
    row_t row;
    row.req.value = value;
    row.req.radix = radix;
    row.req.uppercase = upper;
    row.text = text;
    directed_rows.push_back(row);
  endfunction

  // Random request: mostly supported radices, with values of every magnitude.
  function automatic in_req_t random_request();
    in_req_t     req;
    logic [63:0] raw;
    int unsigned pick;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(0, 11))
      0: raw = 64'd0;
      1: raw = ALL_ONES;
      default: raw = raw >> $urandom_range(0, 63);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      req.radix = RADIX_BIN;
    end else if (pick < 42) begin
      req.radix = RADIX_OCT;
    end else if (pick < 62) begin
      req.radix = RADIX_DEC;
    end else if (pick < 84) begin
      req.radix = RADIX_HEX;
    end else if (pick < 91) begin
      req.radix = $urandom_range(0, 1) ? RADIX_DEF1 : RADIX_DEF0;
    end else begin
      req.radix = 6'($urandom_range(0, 63));
    end
    req.value = raw;
    req.uppercase = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // Holds a request on the input until the block takes it.
  task automatic issue_request(input in_req_t req);
    start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
  endtask

  // Drops start for a random number of cycles on about 9 in a hundred calls that allow it.
  task automatic sender_gap(input bit allow);
    if (allow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
  endtask

  // Stimulus: directed table, then random requests, then drain.
  initial begin
    error_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(64'd0, RADIX_DEC, 1'b0, "0");
    add_row(64'd0, RADIX_BIN, 1'b0, "0");
    add_row(64'd0, RADIX_OCT, 1'b1, "0");
    add_row(64'd0, RADIX_HEX, 1'b1, "0");
    add_row(64'd0, RADIX_DEF0, 1'b0, "0");
    add_row(ALL_ONES, RADIX_HEX, 1'b1, "FFFFFFFFFFFFFFFF");
    add_row(ALL_ONES, RADIX_HEX, 1'b0, "ffffffffffffffff");
    add_row(ALL_ONES, RADIX_BIN, 1'b0, "");
    add_row(ALL_ONES, RADIX_DEC, 1'b1, "18446744073709551615");
    add_row(ALL_ONES, RADIX_DEF1, 1'b0, "18446744073709551615");
    add_row(ALL_ONES, RADIX_OCT, 1'b0, "");
    add_row(64'd123, RADIX_BAD_TOP, 1'b1, "?");
    add_row(64'd0, RADIX_BAD_LOW, 1'b0, "?");
    add_row(ALL_ONES, RADIX_BAD_ABOVE_HEX, 1'b1, "?");
    add_row(64'd77, RADIX_BAD_NINE, 1'b0, "?");
    add_row(64'd1, RADIX_BIN, 1'b1, "1");
    add_row(64'd10, RADIX_DEC, 1'b0, "10");
    add_row(64'd9, RADIX_DEC, 1'b0, "9");
    add_row(64'hAB_CDEF, RADIX_HEX, 1'b1, "ABCDEF");
    add_row(64'hAB_CDEF, RADIX_HEX, 1'b0, "abcdef");
    add_row(64'd255, RADIX_DEC, 1'b1, "255");
    add_row(64'd8, RADIX_OCT, 1'b1, "10");
    add_row(64'h8000_0000_0000_0000, RADIX_BIN, 1'b0, "");
    add_row(64'h0123_4567_89AB_CDEF, RADIX_HEX, 1'b0, "");
    add_row(64'd1, RADIX_DEF0, 1'b0, "1");

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].req);
      if (directed_rows[i].text.len() != 0) begin
        push_text(directed_rows[i].text);
      end else begin
        predict_digits(directed_rows[i].req);
      end
      sender_gap(1'b1);
    end

    // A long stretch in the middle runs back to back with no gaps.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      in_req_t req;
      req = random_request();
      issue_request(req);
      predict_digits(req);
      sender_gap(n < 60 || n >= 110);
    end
    start <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("integer_to_ascii_radix test passed");
    end else begin
      $display("integer_to_ascii_radix test failed");
    end
    $finish;
  end

  // Every character shown must match the oldest one still expected.
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: digit_char %h last %b", out_res.digit_char,
               out_res.last);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_res.digit_char !== want.digit_char) begin
          $error("digit_char mismatch: expected %h actual %h", want.digit_char,
                 out_res.digit_char);
          error_count++;
        end
        if (out_res.last !== want.last) begin
          $error("last mismatch: expected %b actual %b", want.last, out_res.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_to_ascii_radix test failed");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
